// File: src/ymr_pkg.sv
// ----------------------------------------------------------------------------
// YModem receiver package
// Shared types, constants and helper functions of the YModem receiver.
// ----------------------------------------------------------------------------
package ymr_pkg;

  localparam int unsigned MaxChunk = 2048;
  localparam int unsigned CntW = 12;

  localparam int unsigned QDepth = 8;
  localparam int unsigned QPtrW = $clog2(QDepth);
  localparam int unsigned QCntW = $clog2(QDepth + 1);

  localparam logic [7:0] CSoh = 8'h01;
  localparam logic [7:0] CStx = 8'h02;
  localparam logic [7:0] CEot = 8'h04;
  localparam logic [7:0] CAck = 8'h06;
  localparam logic [7:0] CNak = 8'h15;
  localparam logic [7:0] CCan = 8'h18;
  localparam logic [7:0] CCc  = 8'h43;

  typedef enum logic [2:0] {
    KReply   = 3'd0,
    KPayload = 3'd1,
    KCommit  = 3'd2,
    KDiscard = 3'd3,
    KStart   = 3'd4,
    KEnd     = 3'd5
  } kind_e;

  typedef enum logic [1:0] {
    PhIdle = 2'd0,
    PhRecv = 2'd1,
    PhEot  = 2'd2,
    PhBad  = 2'd3
  } phase_e;

  // One result word.
  typedef struct packed {
    kind_e       kind;
    logic [7:0]  value;
    logic [31:0] file_offset;
    logic [10:0] block_size;
    logic        end_status;
    logic        last;
  } res_t;

  // Classified item handed from the front end to the back end.
  typedef struct packed {
    logic [2:0]  cnt;
    res_t [3:0]  res;
  } grp_t;

  function automatic logic [15:0] crc_byte(logic [15:0] crc, logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      c = c[15] ? ((c << 1) ^ 16'h1021) : (c << 1);
    end
    return c;
  endfunction

  function automatic res_t mk(kind_e k, logic [7:0] v, logic [31:0] o,
                              logic [10:0] bs, logic st);
    res_t r;
    r.kind = k;
    r.value = v;
    r.file_offset = o;
    r.block_size = bs;
    r.end_status = st;
    r.last = 1'b0;
    return r;
  endfunction

endpackage

// File: src/ymodem_packet_receiver.sv
// ----------------------------------------------------------------------------
// YModem packet receiver
// Receives YModem chunks byte by byte and emits replies, payload and events.
// ----------------------------------------------------------------------------
// Channel | Dir | tdata                                      | tuser  | tlast
// s_axis  | in  | data_byte                                  | action | chunk_end
// m_axis  | out | value, file_offset, block_size, end_status | kind   | last
//
// One byte is accepted per cycle; each produces zero to four result words.
// Result words are registered into the queue when their byte is accepted.
// Results leave one per cycle, while the sink takes them, from an eight-word queue.
// Input is held off while the queue has fewer than four free entries.
// Reset is asynchronous and needs no clearing pass.
// ----------------------------------------------------------------------------
module ymodem_packet_receiver (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,  // data_byte
  input  logic        s_axis_tuser,  // action
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [55:0] m_axis_tdata,  // value, file_offset, block_size,
                                     // end_status, zeros
  output logic [2:0]  m_axis_tuser,  // kind
  output logic        m_axis_tlast
);
  import ymr_pkg::*;

  grp_t grp;
  res_t res;
  logic acc;

  assign acc = s_axis_tvalid && s_axis_tready;

  ymr_front u_front (
    .clk_i(clk_i), .rst_ni(rst_ni), .in_valid_i(acc),
    .action_i(s_axis_tuser), .data_byte_i(s_axis_tdata),
    .chunk_end_i(s_axis_tlast), .grp_o(grp)
  );

  ymr_back u_back (
    .clk_i(clk_i), .rst_ni(rst_ni), .push_i(acc), .grp_i(grp),
    .ready_o(s_axis_tready), .valid_o(m_axis_tvalid), .res_o(res),
    .take_i(m_axis_tready)
  );

  assign m_axis_tdata = {4'b0, res.end_status, res.block_size, res.file_offset,
                         res.value};
  assign m_axis_tuser = res.kind;
  assign m_axis_tlast = res.last;
endmodule

// File: src/ymr_front.sv
// ----------------------------------------------------------------------------
// YModem receiver front end
// Tracks chunk state, checks packets and builds the group of results per byte.
// ----------------------------------------------------------------------------
module ymr_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  input  logic          action_i,
  input  logic [7:0]    data_byte_i,
  input  logic          chunk_end_i,
  output ymr_pkg::grp_t grp_o
);
  import ymr_pkg::*;

  phase_e          phase_q, phase_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [31:0]     seek_q, seek_d;
  logic [15:0]     crc_q, crc_d;
  logic [7:0]      d0_q, d0_d, d1_q, d1_d;
  logic [7:0]      lead_q, lead_d, seq_q, seq_d, cmp_q, cmp_d, fdb_q, fdb_d;
  logic            nz_q, nz_d, same_q, same_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhIdle;
      cnt_q <= '0;
      seek_q <= '0;
      crc_q <= '0;
      d0_q <= '0;
      d1_q <= '0;
      lead_q <= '0;
      seq_q <= '0;
      cmp_q <= '0;
      fdb_q <= '0;
      nz_q <= 1'b0;
      same_q <= 1'b1;
    end else if (in_valid_i) begin
      phase_q <= phase_d;
      cnt_q <= cnt_d;
      seek_q <= seek_d;
      crc_q <= crc_d;
      d0_q <= d0_d;
      d1_q <= d1_d;
      lead_q <= lead_d;
      seq_q <= seq_d;
      cmp_q <= cmp_d;
      fdb_q <= fdb_d;
      nz_q <= nz_d;
      same_q <= same_d;
    end
  end

  logic [10:0] bs;
  logic        dlead, cmd_ok, data_ok, pay;
  logic [7:0]  sum8;
  res_t [3:0]  r;
  logic [2:0]  n;

  always_comb begin
    phase_d = phase_q;
    cnt_d = cnt_q;
    seek_d = seek_q;
    crc_d = crc_q;
    d0_d = d0_q;
    d1_d = d1_q;
    lead_d = lead_q;
    seq_d = seq_q;
    cmp_d = cmp_q;
    fdb_d = fdb_q;
    nz_d = nz_q;
    same_d = same_q;
    r = '0;
    n = 3'd0;
    bs = 11'd1024;
    dlead = 1'b0;
    cmd_ok = 1'b0;
    data_ok = 1'b0;
    pay = 1'b0;
    sum8 = '0;
    if (action_i) begin
      r[0] = mk(KReply, CCc, '0, '0, 1'b0);
      n = 3'd1;
    end else begin
      d1_d = d0_q;
      d0_d = data_byte_i;
      if (cnt_q == '0) begin
        lead_d = data_byte_i;
      end else if (data_byte_i != lead_q) begin
        same_d = 1'b0;
      end
      if (cnt_q == CntW'(1)) seq_d = data_byte_i;
      if (cnt_q == CntW'(2)) cmp_d = data_byte_i;
      if (cnt_q == CntW'(3)) fdb_d = data_byte_i;
      bs = (lead_d == CSoh) ? 11'd128 : 11'd1024;
      dlead = (lead_d == CSoh) || (lead_d == CStx);
      if (cnt_q >= CntW'(5) && (cnt_q - CntW'(5)) < CntW'(bs)) begin
        crc_d = crc_byte(crc_q, d1_q);
        if (d1_q != 8'd0) nz_d = 1'b1;
        if (phase_q == PhRecv && dlead) begin
          r[0] = mk(KPayload, d1_q, seek_q + 32'(cnt_q - CntW'(5)), '0, 1'b0);
          n = 3'd1;
          pay = 1'b1;
        end
      end
      if (cnt_q <= CntW'(MaxChunk)) cnt_d = cnt_q + CntW'(1);
      if (chunk_end_i) begin
        sum8 = seq_d + cmp_d;
        cmd_ok = cnt_d < CntW'(128) && same_d &&
                 (lead_d == CEot || lead_d == CAck || lead_d == CNak ||
                  lead_d == CCan || lead_d == CCc);
        data_ok = cnt_d >= CntW'(128) && cnt_d <= CntW'(MaxChunk) && dlead &&
                  cnt_d == CntW'(bs) + CntW'(5) && crc_d == {d1_d, d0_d} &&
                  sum8 == 8'hff;
        // All ending paths; after an end the whole state returns to reset.
        case (phase_q)
          PhIdle: begin
            if (data_ok && !nz_d) begin
              r[n] = mk(KReply, CAck, '0, '0, 1'b0);
              r[n+3'd1] = mk(KEnd, '0, '0, '0, 1'b0);
              n = n + 3'd2;
              phase_d = PhBad;
            end else if (data_ok && bs == 11'd128) begin
              r[n] = mk(KStart, fdb_d, '0, 11'd128, 1'b0);
              r[n+3'd1] = mk(KReply, CAck, '0, '0, 1'b0);
              r[n+3'd2] = mk(KReply, CCc, '0, '0, 1'b0);
              n = n + 3'd3;
              seek_d = '0;
              phase_d = PhRecv;
            end else if (!data_ok && cmd_ok && lead_d == CEot) begin
              r[n] = mk(KEnd, '0, '0, '0, 1'b0);
              n = n + 3'd1;
              phase_d = PhBad;
            end else begin
              r[n] = mk(KReply, CCan, '0, '0, 1'b0);
              r[n+3'd1] = mk(KEnd, '0, '0, '0, 1'b1);
              n = n + 3'd2;
              phase_d = PhBad;
            end
          end
          PhRecv: begin
            if (data_ok) begin
              r[n] = mk(KReply, CAck, '0, '0, 1'b0);
              r[n+3'd1] = mk(KCommit, '0, seek_q, bs, 1'b0);
              r[n+3'd2] = mk(KReply, CCc, '0, '0, 1'b0);
              n = n + 3'd3;
              seek_d = seek_q + 32'(bs);
            end else if (cmd_ok && lead_d == CEot) begin
              r[n] = mk(KReply, CNak, '0, '0, 1'b0);
              n = n + 3'd1;
              phase_d = PhEot;
            end else if (cmd_ok && lead_d == CCan) begin
              r[n] = mk(KReply, CCan, '0, '0, 1'b0);
              r[n+3'd1] = mk(KEnd, '0, '0, '0, 1'b1);
              n = n + 3'd2;
              phase_d = PhBad;
            end else begin
              if (dlead) begin
                r[n] = mk(KDiscard, '0, seek_q, bs, 1'b0);
                n = n + 3'd1;
              end
              r[n] = mk(KReply, CNak, '0, '0, 1'b0);
              n = n + 3'd1;
            end
          end
          PhEot: begin
            if (cmd_ok && lead_d == CEot) begin
              r[n] = mk(KReply, CAck, '0, '0, 1'b0);
              r[n+3'd1] = mk(KEnd, '0, '0, '0, 1'b0);
              n = n + 3'd2;
            end else begin
              r[n] = mk(KReply, CCan, '0, '0, 1'b0);
              r[n+3'd1] = mk(KEnd, '0, '0, '0, 1'b1);
              n = n + 3'd2;
            end
            phase_d = PhBad;
          end
          default: begin
            r[n] = mk(KReply, CCan, '0, '0, 1'b0);
            r[n+3'd1] = mk(KEnd, '0, '0, '0, 1'b1);
            n = n + 3'd2;
          end
        endcase
        // Chunk state clears at every chunk end; an end also clears phase and offset.
        cnt_d = '0;
        crc_d = '0;
        d0_d = '0;
        d1_d = '0;
        lead_d = '0;
        seq_d = '0;
        cmp_d = '0;
        fdb_d = '0;
        nz_d = 1'b0;
        same_d = 1'b1;
        if (phase_d == PhBad) begin
          phase_d = PhIdle;
          seek_d = '0;
        end
      end
    end
    if (n != 3'd0) r[n-3'd1].last = 1'b1;
    grp_o.cnt = n;
    grp_o.res = r;
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q != PhBad) else $error("Unused phase reached.");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(MaxChunk + 1)) else $error("Byte count beyond saturation.");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && pay |-> !chunk_end_i || grp_o.cnt >= 3'd2)
    else $error("Payload at chunk end without verdict.");
endmodule

// File: src/ymr_back.sv
// ----------------------------------------------------------------------------
// YModem receiver back end
// Queues result groups and sends their words one per cycle while the sink takes them.
// ----------------------------------------------------------------------------
module ymr_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  ymr_pkg::grp_t grp_i,
  output logic          ready_o,
  output logic          valid_o,
  output ymr_pkg::res_t res_o,
  input  logic          take_i
);
  import ymr_pkg::*;

  res_t             mem_q [QDepth];
  logic [QPtrW-1:0] wp_q, rp_q;
  logic [QCntW-1:0] cnt_q;
  logic [QCntW-1:0] cnt_d;
  logic [2:0]       nw;
  logic             pop;

  assign nw = push_i ? grp_i.cnt : 3'd0;
  assign pop = valid_o && take_i;
  assign valid_o = cnt_q != '0;
  assign res_o = mem_q[rp_q];
  assign ready_o = cnt_q <= QCntW'(QDepth - 4);
  assign cnt_d = cnt_q + QCntW'(nw) - QCntW'(pop);

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 4; i++) begin
      if (3'(i) < nw) mem_q[wp_q + QPtrW'(i)] <= grp_i.res[i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= '0;
      rp_q <= '0;
      cnt_q <= '0;
    end else begin
      wp_q <= wp_q + QPtrW'(nw);
      rp_q <= rp_q + QPtrW'(pop);
      cnt_q <= cnt_d;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= QCntW'(QDepth)) else $error("Queue overflow.");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> grp_i.cnt <= 3'd4) else $error("Group too large.");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !push_i && !pop |=> $stable(cnt_q)) else $error("Count moved while quiet.");
endmodule
